// ----- hw/rtl/ssp_pkg.sv -----
// Shared types and constants for the sprite screen projection block.
package ssp_pkg;

    // Configuration port.
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_POS_X   = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POS_Y   = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DIR_X   = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DIR_Y   = 4'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PLANE_X = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PLANE_Y = 4'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SCR_W   = 4'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SCR_H   = 4'd7;

    // Datapath widths, sized for the full range of every register pattern.
    localparam int SX_W        = 34;
    localparam int PROD_W      = 50;
    localparam int N_W         = 52;
    localparam int SUM_W       = 53;
    localparam int DET_W       = 33;
    localparam int DEPTH_NUM_W = 63;
    localparam int DEPTH_DEN_W = 32;
    localparam int DEPTH_Q_W   = 31;
    localparam int COL_NUM_W   = 64;
    localparam int COL_DEN_W   = 52;
    localparam int SIZE_NUM_W  = 36;
    localparam int SIZE_DEN_W  = 38;
    localparam int POST_Q_W    = 16;

    // Size is W * 0.66 / depth, done as W * 66 / 100.
    localparam int SIZE_MUL = 66;
    localparam int SIZE_DIV = 100;

    typedef struct packed {
        logic [23:0]        pos_x;
        logic [23:0]        pos_y;
        logic signed [15:0] dir_x;
        logic signed [15:0] dir_y;
        logic signed [15:0] plane_x;
        logic signed [15:0] plane_y;
        logic [12:0]        scr_w;
        logic [12:0]        scr_h;
    } t_cfg;

    typedef struct packed {
        logic [7:0] sprite_cell_x;
        logic [7:0] sprite_cell_y;
    } t_sprite_in;

    typedef struct packed {
        logic signed [31:0] depth;
        logic signed [15:0] screen_column;
        logic [15:0]        sprite_size;
        logic [14:0]        first_column;
        logic signed [15:0] last_column;
        logic [10:0]        first_row;
        logic [11:0]        last_row;
        logic               degenerate;
    } t_sprite_out;

    // Carried alongside the depth division.
    typedef struct packed {
        logic             det_zero;
        logic             depth_neg;
        logic             col_neg;
        logic [SUM_W-1:0] sum_mag;
        logic [N_W-1:0]   ny_mag;
    } t_dside;

    typedef struct packed {
        logic [DEPTH_NUM_W-1:0] depth_num;
        logic [DEPTH_DEN_W-1:0] depth_den;
        t_dside                 side;
    } t_front;

    // Carried alongside the column division.
    typedef struct packed {
        logic signed [31:0] depth;
        logic               col_neg;
    } t_cside;

endpackage

// ----- hw/rtl/ssp_front.sv -----
// Front end: cell offset, camera matrix products and divider operand setup.
module ssp_front import ssp_pkg::*; #(
    parameter int POS_FRAC_BITS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  t_sprite_in i_item,
    input  t_cfg       i_cfg,
    output logic       o_valid,
    output t_front     o_data
);

    localparam int SHIFT = 30 - POS_FRAC_BITS;

    logic                     r_a_v, r_b_v, r_c_v, r_d_v;
    logic signed [SX_W-1:0]   r_sx, r_sy;
    logic signed [PROD_W-1:0] r_dysx, r_dxsy, r_pxsy, r_pysx;
    logic signed [31:0]       r_pxdy, r_dxpy;
    logic signed [N_W-1:0]    r_nx, r_ny;
    logic signed [DET_W-1:0]  r_det;
    t_front                   r_out;

    logic [SX_W-1:0]          n_sx, n_sy;
    logic signed [SUM_W-1:0]  sum;
    logic [N_W-1:0]           ny_mag;
    logic [SUM_W-1:0]         sum_mag;
    logic [DEPTH_DEN_W-1:0]   det_mag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
            r_d_v <= 1'b0;
        end else begin
            r_a_v <= i_valid;
            r_b_v <= r_a_v;
            r_c_v <= r_b_v;
            r_d_v <= r_c_v;
        end
    end

    // Cell center minus camera position.
    assign n_sx = (SX_W'(i_item.sprite_cell_x) << POS_FRAC_BITS)
                + (SX_W'(1) << (POS_FRAC_BITS - 1)) - SX_W'(i_cfg.pos_x);
    assign n_sy = (SX_W'(i_item.sprite_cell_y) << POS_FRAC_BITS)
                + (SX_W'(1) << (POS_FRAC_BITS - 1)) - SX_W'(i_cfg.pos_y);

    always_comb begin
        sum     = SUM_W'(r_nx) + SUM_W'(r_ny);
        ny_mag  = r_ny[N_W-1] ? N_W'(-r_ny) : N_W'(r_ny);
        sum_mag = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
        det_mag = r_det[DET_W-1] ? DEPTH_DEN_W'(-r_det) : DEPTH_DEN_W'(r_det);
    end

    always_ff @(posedge i_clk) begin
        r_sx   <= $signed(n_sx);
        r_sy   <= $signed(n_sy);
        r_dysx <= PROD_W'(i_cfg.dir_y) * PROD_W'(r_sx);
        r_dxsy <= PROD_W'(i_cfg.dir_x) * PROD_W'(r_sy);
        r_pxsy <= PROD_W'(i_cfg.plane_x) * PROD_W'(r_sy);
        r_pysx <= PROD_W'(i_cfg.plane_y) * PROD_W'(r_sx);
        r_pxdy <= 32'(i_cfg.plane_x) * 32'(i_cfg.dir_y);
        r_dxpy <= 32'(i_cfg.dir_x) * 32'(i_cfg.plane_y);
        r_nx   <= N_W'(r_dysx) - N_W'(r_dxsy);
        r_ny   <= N_W'(r_pxsy) - N_W'(r_pysx);
        r_det  <= DET_W'(r_pxdy) - DET_W'(r_dxpy);
        r_out.depth_num      <= DEPTH_NUM_W'(ny_mag) << SHIFT;
        r_out.depth_den      <= det_mag;
        r_out.side.det_zero  <= (r_det == '0);
        r_out.side.depth_neg <= r_ny[N_W-1] ^ r_det[DET_W-1];
        r_out.side.col_neg   <= sum[SUM_W-1] ^ r_ny[N_W-1];
        r_out.side.sum_mag   <= sum_mag;
        r_out.side.ny_mag    <= ny_mag;
    end

    assign o_valid = r_d_v;
    assign o_data  = r_out;

endmodule

// ----- hw/rtl/ssp_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, with overflow precheck.
module ssp_div import ssp_pkg::*; #(
    parameter int NUM_W  = 32,
    parameter int DEN_W  = 16,
    parameter int Q_W    = 16,
    parameter int SIDE_W = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [NUM_W-1:0]  i_num,
    input  logic [DEN_W-1:0]  i_den,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output logic [Q_W-1:0]    o_quot,
    output logic              o_ovf,
    output logic [SIDE_W-1:0] o_side
);

    localparam int RW = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

    logic              r_v    [0:Q_W];
    logic [RW-1:0]     r_rem  [0:Q_W];
    logic [DEN_W-1:0]  r_den  [0:Q_W];
    logic [Q_W-1:0]    r_q    [0:Q_W];
    logic              r_ovf  [0:Q_W];
    logic [SIDE_W-1:0] r_side [0:Q_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else begin
            r_v[0] <= i_valid;
        end
    end

    // A quotient that does not fit in Q_W bits is flagged; its quotient bits are then not meaningful.
    always_ff @(posedge i_clk) begin
        r_rem[0]  <= RW'(i_num);
        r_den[0]  <= i_den;
        r_q[0]    <= '0;
        r_ovf[0]  <= RW'(i_num) >= (RW'(i_den) << Q_W);
        r_side[0] <= i_side;
    end

    for (genvar k = 1; k <= Q_W; k++) begin : g_stage
        localparam int B = Q_W - k;
        logic [RW-1:0] trial;
        logic          fit;

        assign trial = RW'(r_den[k-1]) << B;
        assign fit   = r_rem[k-1] >= trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else begin
                r_v[k] <= r_v[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[k]  <= fit ? r_rem[k-1] - trial : r_rem[k-1];
            r_den[k]  <= r_den[k-1];
            r_q[k]    <= fit ? (r_q[k-1] | (Q_W'(1) << B)) : r_q[k-1];
            r_ovf[k]  <= r_ovf[k-1];
            r_side[k] <= r_side[k-1];
        end
    end

    assign o_valid = r_v[Q_W];
    assign o_quot  = r_q[Q_W];
    assign o_ovf   = r_ovf[Q_W];
    assign o_side  = r_side[Q_W];

endmodule

// ----- hw/rtl/ssp_mid.sv -----
// Depth finish, degenerate detection and operand setup for column and size.
module ssp_mid import ssp_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic [DEPTH_Q_W-1:0]  i_quot,
    input  logic                  i_ovf,
    input  t_dside                i_side,
    input  t_cfg                  i_cfg,
    output logic                  o_valid,
    output logic [COL_NUM_W-1:0]  o_col_num,
    output logic [COL_DEN_W-1:0]  o_col_den,
    output t_cside                o_col_side,
    output logic [SIZE_NUM_W-1:0] o_size_num,
    output logic [SIZE_DEN_W-1:0] o_size_den,
    output logic                  o_degen
);

    logic                  r_v;
    logic [COL_NUM_W-1:0]  r_col_num;
    logic [COL_DEN_W-1:0]  r_col_den;
    t_cside                r_col_side;
    logic [SIZE_NUM_W-1:0] r_size_num;
    logic [SIZE_DEN_W-1:0] r_size_den;
    logic                  r_degen;

    logic signed [31:0]    depth;
    logic [31:0]           mag;
    logic                  degen;

    always_comb begin
        if (i_side.det_zero) begin
            depth = '0;
            mag   = '0;
        end else if (i_ovf) begin
            depth = i_side.depth_neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
            mag   = i_side.depth_neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else begin
            depth = i_side.depth_neg ? -$signed(32'(i_quot)) : $signed(32'(i_quot));
            mag   = 32'(i_quot);
        end
        degen = i_side.det_zero || (!i_ovf && i_quot == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_col_num          <= COL_NUM_W'(i_cfg.scr_w[12:1]) * COL_NUM_W'(i_side.sum_mag);
        r_col_den          <= i_side.ny_mag;
        r_col_side.depth   <= depth;
        r_col_side.col_neg <= i_side.col_neg;
        r_size_num         <= (SIZE_NUM_W'(i_cfg.scr_w) * SIZE_NUM_W'(SIZE_MUL)) << 16;
        r_size_den         <= SIZE_DEN_W'(mag) * SIZE_DEN_W'(SIZE_DIV);
        r_degen            <= degen;
    end

    assign o_valid    = r_v;
    assign o_col_num  = r_col_num;
    assign o_col_den  = r_col_den;
    assign o_col_side = r_col_side;
    assign o_size_num = r_size_num;
    assign o_size_den = r_size_den;
    assign o_degen    = r_degen;

endmodule

// ----- hw/rtl/ssp_back.sv -----
// Back end: column and size saturation, then draw bound clamping.
module ssp_back import ssp_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_col_valid,
    input  logic [POST_Q_W-1:0] i_col_quot,
    input  logic                i_col_ovf,
    input  t_cside              i_col_side,
    input  logic                i_size_valid,
    input  logic [POST_Q_W-1:0] i_size_quot,
    input  logic                i_size_ovf,
    input  logic                i_degen,
    input  t_cfg                i_cfg,
    output logic                o_valid,
    output t_sprite_out         o_result
);

    logic               r1_v, r2_v;
    logic signed [31:0] r1_depth;
    logic signed [15:0] r1_col;
    logic [15:0]        r1_size;
    logic               r1_degen;
    t_sprite_out        r2_out;

    logic [16:0]        col_mag;
    logic signed [15:0] col;
    logic [14:0]        half;
    logic signed [17:0] fc, lc, scr_w;
    logic signed [16:0] fr, lr, scr_h;
    logic [11:0]        half_h;

    always_comb begin
        col_mag = i_col_ovf ? 17'h10000 : 17'(i_col_quot);
        if (i_degen) begin
            col = 16'sh7FFF;
        end else if (!i_col_side.col_neg) begin
            col = (col_mag > 17'd32767) ? 16'sh7FFF : $signed(col_mag[15:0]);
        end else begin
            col = (col_mag > 17'd32768) ? 16'sh8000 : -$signed(col_mag[15:0]);
        end
    end

    always_comb begin
        half   = r1_size[15:1];
        half_h = i_cfg.scr_h[12:1];
        scr_w  = $signed(18'(i_cfg.scr_w));
        scr_h  = $signed(17'(i_cfg.scr_h));
        fc     = 18'(r1_col) - $signed(18'(half));
        lc     = 18'(r1_col) + $signed(18'(half));
        if (lc >= scr_w) begin
            lc = scr_w - 18'sd1;
        end
        fr     = $signed(17'(half_h)) - $signed(17'(half));
        lr     = $signed(17'(half)) + $signed(17'(half_h));
        if (lr >= scr_h) begin
            lr = scr_h - 17'sd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
        end else begin
            r1_v <= i_col_valid && i_size_valid;
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_depth <= i_col_side.depth;
        r1_col   <= col;
        r1_size  <= (i_degen || i_size_ovf) ? 16'hFFFF : i_size_quot;
        r1_degen <= i_degen;

        r2_out.depth         <= r1_depth;
        r2_out.screen_column <= r1_col;
        r2_out.sprite_size   <= r1_size;
        r2_out.first_column  <= fc[17] ? 15'd0 : fc[14:0];
        r2_out.last_column   <= lc[15:0];
        r2_out.first_row     <= fr[16] ? 11'd0 : ((fr > 17'sd2047) ? 11'd2047 : fr[10:0]);
        r2_out.last_row      <= lr[16] ? 12'd0 : ((lr > 17'sd4095) ? 12'd4095 : lr[11:0]);
        r2_out.degenerate    <= r1_degen;
    end

    assign o_valid  = r2_v;
    assign o_result = r2_out;

endmodule

// ----- hw/rtl/sprite_screen_projection.sv -----
// Top level of the sprite screen projection block.
// Usage: write the camera position, view direction, camera plane and screen
// size through the configuration channel (index, data, valid/ready; ready is
// always high). The user must write registers only while no item is in
// flight; the block does not enforce this. Pulse i_start with a sprite map
// cell in i_item; busy stays low, so an item is taken on every cycle that
// start is high. Each item produces one result on o_result, marked by a
// one-cycle strobe o_result_valid. The path is a fixed pipeline: 4 front
// stages for the offset and camera products, 32 stages of the depth
// divider, one setup stage, 17 stages of the parallel column and size
// dividers and 2 clamp stages. One item per cycle is sustained. The result
// is not held: the receiver has to take it in the strobe cycle.
// Reset clears all pipeline valid bits, so items in flight are dropped, and
// loads the default camera: position 0,0, direction 1,0, plane 0,0.66 and a
// 640 by 480 screen.
module sprite_screen_projection import ssp_pkg::*; #(
    parameter int POS_FRAC_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    output logic                  o_busy,
    input  t_sprite_in            i_item,
    output logic                  o_result_valid,
    output t_sprite_out           o_result,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg                  r_cfg;

    logic                  front_v;
    t_front                front_data;
    logic                  dd_v, dd_ovf;
    logic [DEPTH_Q_W-1:0]  dd_quot;
    t_dside                dd_side;
    logic                  mid_v, mid_degen;
    logic [COL_NUM_W-1:0]  col_num;
    logic [COL_DEN_W-1:0]  col_den;
    t_cside                col_side_in, col_side_out;
    logic [SIZE_NUM_W-1:0] size_num;
    logic [SIZE_DEN_W-1:0] size_den;
    logic                  cd_v, cd_ovf, sd_v, sd_ovf, sd_degen;
    logic [POST_Q_W-1:0]   cd_quot, sd_quot;

    assign o_busy      = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pos_x   <= 24'd0;
            r_cfg.pos_y   <= 24'd0;
            r_cfg.dir_x   <= 16'sd16384;
            r_cfg.dir_y   <= 16'sd0;
            r_cfg.plane_x <= 16'sd0;
            r_cfg.plane_y <= 16'sd10813;
            r_cfg.scr_w   <= 13'd640;
            r_cfg.scr_h   <= 13'd480;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_POS_X:   r_cfg.pos_x   <= i_cfg_data;
                CFG_POS_Y:   r_cfg.pos_y   <= i_cfg_data;
                CFG_DIR_X:   r_cfg.dir_x   <= $signed(i_cfg_data[15:0]);
                CFG_DIR_Y:   r_cfg.dir_y   <= $signed(i_cfg_data[15:0]);
                CFG_PLANE_X: r_cfg.plane_x <= $signed(i_cfg_data[15:0]);
                CFG_PLANE_Y: r_cfg.plane_y <= $signed(i_cfg_data[15:0]);
                CFG_SCR_W:   r_cfg.scr_w   <= i_cfg_data[12:0];
                CFG_SCR_H:   r_cfg.scr_h   <= i_cfg_data[12:0];
                default: begin
                end
            endcase
        end
    end

    ssp_front #(
        .POS_FRAC_BITS(POS_FRAC_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_start && !o_busy),
        .i_item  (i_item),
        .i_cfg   (r_cfg),
        .o_valid (front_v),
        .o_data  (front_data)
    );

    ssp_div #(
        .NUM_W  (DEPTH_NUM_W),
        .DEN_W  (DEPTH_DEN_W),
        .Q_W    (DEPTH_Q_W),
        .SIDE_W ($bits(t_dside))
    ) u_depth_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (front_v),
        .i_num   (front_data.depth_num),
        .i_den   (front_data.depth_den),
        .i_side  (front_data.side),
        .o_valid (dd_v),
        .o_quot  (dd_quot),
        .o_ovf   (dd_ovf),
        .o_side  (dd_side)
    );

    ssp_mid u_mid (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (dd_v),
        .i_quot     (dd_quot),
        .i_ovf      (dd_ovf),
        .i_side     (dd_side),
        .i_cfg      (r_cfg),
        .o_valid    (mid_v),
        .o_col_num  (col_num),
        .o_col_den  (col_den),
        .o_col_side (col_side_in),
        .o_size_num (size_num),
        .o_size_den (size_den),
        .o_degen    (mid_degen)
    );

    ssp_div #(
        .NUM_W  (COL_NUM_W),
        .DEN_W  (COL_DEN_W),
        .Q_W    (POST_Q_W),
        .SIDE_W ($bits(t_cside))
    ) u_col_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (mid_v),
        .i_num   (col_num),
        .i_den   (col_den),
        .i_side  (col_side_in),
        .o_valid (cd_v),
        .o_quot  (cd_quot),
        .o_ovf   (cd_ovf),
        .o_side  (col_side_out)
    );

    ssp_div #(
        .NUM_W  (SIZE_NUM_W),
        .DEN_W  (SIZE_DEN_W),
        .Q_W    (POST_Q_W),
        .SIDE_W (1)
    ) u_size_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (mid_v),
        .i_num   (size_num),
        .i_den   (size_den),
        .i_side  (mid_degen),
        .o_valid (sd_v),
        .o_quot  (sd_quot),
        .o_ovf   (sd_ovf),
        .o_side  (sd_degen)
    );

    ssp_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_col_valid  (cd_v),
        .i_col_quot   (cd_quot),
        .i_col_ovf    (cd_ovf),
        .i_col_side   (col_side_out),
        .i_size_valid (sd_v),
        .i_size_quot  (sd_quot),
        .i_size_ovf   (sd_ovf),
        .i_degen      (sd_degen),
        .i_cfg        (r_cfg),
        .o_valid      (o_result_valid),
        .o_result     (o_result)
    );

endmodule

// ----- hw/rtl/ssp_checker.sv -----
// Port-level checks for the sprite screen projection block, bound to the top level.
module ssp_checker import ssp_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_start,
    input logic        o_busy,
    input logic        o_result_valid,
    input t_sprite_out o_result
);

    localparam int LATENCY = 56;

    // Every result traces back to an item taken a fixed time earlier.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(i_start && !o_busy, LATENCY))
        else $error("result without an item taken %0d cycles before", LATENCY);

    // A degenerate projection reports the saturated column and size.
    a_degen_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_result.degenerate) |->
            (o_result.screen_column == 16'sh7FFF && o_result.sprite_size == 16'hFFFF))
        else $error("degenerate result without saturated column and size");

    // A projection that is not degenerate has a nonzero depth.
    a_depth_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && !o_result.degenerate) |-> (o_result.depth != 32'sd0))
        else $error("zero depth not flagged as degenerate");

endmodule

bind sprite_screen_projection ssp_checker u_ssp_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_start        (i_start),
    .o_busy         (o_busy),
    .o_result_valid (o_result_valid),
    .o_result       (o_result)
);

// ----- tb/sv/tb_top.sv -----
// Self-checking testbench for the sprite screen projection block.
`timescale 1ns / 1ps

import ssp_pkg::*;

class projection_board;
    t_sprite_out pending_results[$];
    int          mismatch_count;
    int          unexpected_count;

    function void note_sprite(t_sprite_out predicted);
        pending_results.push_back(predicted);
    endfunction

    function void check_result(t_sprite_out actual);
        t_sprite_out want;
        if (pending_results.size() == 0) begin
            unexpected_count++;
            if (mismatch_count + unexpected_count <= 10)
                $display("Result arrived with none pending: %p", actual);
            return;
        end
        want = pending_results.pop_front();
        if (want.depth !== actual.depth || want.screen_column !== actual.screen_column ||
            want.sprite_size !== actual.sprite_size ||
            want.first_column !== actual.first_column ||
            want.last_column !== actual.last_column || want.first_row !== actual.first_row ||
            want.last_row !== actual.last_row || want.degenerate !== actual.degenerate) begin
            mismatch_count++;
            if (mismatch_count + unexpected_count <= 10)
                $display("Mismatch: expected %p, got %p", want, actual);
        end
    endfunction
endclass

module tb_top;
    localparam int FRAC = 16;
    localparam int PIPE_LATENCY = 56;
    localparam longint CYCLE_LIMIT = 400000;
    // An index past the last register; the block ignores writes to it.
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 4'd12;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_start = 1'b0;
    logic        o_busy;
    t_sprite_in  i_item = '0;
    logic        o_result_valid;
    t_sprite_out o_result;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    projection_board board = new();
    t_cfg  camera;
    longint cycle_count = 0;

    sprite_screen_projection #(.POS_FRAC_BITS(FRAC)) i_dut (.*);

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("FAILED: results differ");
            $finish;
        end
    end

    always @(posedge i_clk)
        if (i_rst_n && o_result_valid) board.check_result(o_result);

    function automatic longint clamp_range(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic t_sprite_out project_sprite(t_sprite_in spr);
        t_sprite_out r;
        longint sx, sy, dx, dy, px, py, w, h, det, nx, ny, dep, col, sz, half, fc, lc, fr, lr;
        longint unsigned mag, q;
        bit degen;
        sx = (longint'(spr.sprite_cell_x) <<< FRAC) + (64'sd1 <<< (FRAC - 1))
             - longint'(camera.pos_x);
        sy = (longint'(spr.sprite_cell_y) <<< FRAC) + (64'sd1 <<< (FRAC - 1))
             - longint'(camera.pos_y);
        dx = camera.dir_x;
        dy = camera.dir_y;
        px = camera.plane_x;
        py = camera.plane_y;
        w = camera.scr_w;
        h = camera.scr_h;
        det = px * dy - dx * py;
        nx = dy * sx - dx * sy;
        ny = px * sy - py * sx;
        dep = 0;
        if (det != 0) dep = clamp_range((ny * (64'sd1 <<< (30 - FRAC))) / det,
                                        -64'sd2147483648, 64'sd2147483647);
        degen = (det == 0) || (dep == 0);
        if (degen) begin
            col = 32767;
            sz = 65535;
        end else begin
            mag = dep < 0 ? -dep : dep;
            q = (longint'(w) * 66 * 65536) / (100 * mag);
            col = clamp_range(((w / 2) * (nx + ny)) / ny, -32768, 32767);
            sz = q > 65535 ? 65535 : q;
        end
        half = sz / 2;
        fc = col - half;
        if (fc < 0) fc = 0;
        lc = col + half;
        if (lc >= w) lc = w - 1;
        fr = clamp_range(h / 2 - half, 0, 2047);
        lr = half + h / 2;
        if (lr >= h) lr = h - 1;
        lr = clamp_range(lr, 0, 4095);
        r.depth = dep[31:0];
        r.screen_column = col[15:0];
        r.sprite_size = sz[15:0];
        r.first_column = fc[14:0];
        r.last_column = lc[15:0];
        r.first_row = fr[10:0];
        r.last_row = lr[11:0];
        r.degenerate = degen;
        return r;
    endfunction

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        unique case (idx)
            CFG_POS_X:   camera.pos_x = value;
            CFG_POS_Y:   camera.pos_y = value;
            CFG_DIR_X:   camera.dir_x = value[15:0];
            CFG_DIR_Y:   camera.dir_y = value[15:0];
            CFG_PLANE_X: camera.plane_x = value[15:0];
            CFG_PLANE_Y: camera.plane_y = value[15:0];
            CFG_SCR_W:   camera.scr_w = value[12:0];
            CFG_SCR_H:   camera.scr_h = value[12:0];
            default: ;
        endcase
    endtask

    task automatic drain_pipeline();
        i_start <= 1'b0;
        while (board.pending_results.size() != 0) @(posedge i_clk);
        repeat (PIPE_LATENCY + 4) @(posedge i_clk);
    endtask

    // Keeps start high across back-to-back items; lowers it only for a gap.
    task automatic send_sprite(t_sprite_in spr);
        int gap;
        i_start <= 1'b1;
        i_item <= spr;
        do @(posedge i_clk); while (o_busy);
        board.note_sprite(project_sprite(spr));
        gap = ($urandom_range(0, 9) < 6) ? 0 :
              (($urandom_range(0, 19) == 0) ? $urandom_range(10, 70) : $urandom_range(1, 4));
        if (gap != 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_cell(int x, int y);
        t_sprite_in c;
        c.sprite_cell_x = 8'(x);
        c.sprite_cell_y = 8'(y);
        send_sprite(c);
    endtask

    task automatic random_camera(int kind);
        int v;
        write_register(CFG_POS_X, kind == 0 ? 24'hFFFFFF : 24'($urandom_range(0, 24'hFFFFFF)));
        write_register(CFG_POS_Y, kind == 0 ? 24'h000000 : 24'($urandom_range(0, 24'hFFFFFF)));
        v = $urandom_range(0, 32768);
        write_register(CFG_DIR_X, kind == 0 ? 24'(-16384) : 24'(v - 16384));
        v = $urandom_range(0, 32768);
        write_register(CFG_DIR_Y, kind == 0 ? 24'(16384) : 24'(v - 16384));
        v = $urandom_range(0, 32768);
        write_register(CFG_PLANE_X, kind == 0 ? 24'(16384) : 24'(v - 16384));
        v = $urandom_range(0, 32768);
        write_register(CFG_PLANE_Y, kind == 0 ? 24'(-16384) : 24'(v - 16384));
        write_register(CFG_SCR_W, kind == 0 ? 24'd4096 : 24'($urandom_range(1, 4096)));
        write_register(CFG_SCR_H, kind == 0 ? 24'd1 : 24'($urandom_range(1, 4096)));
    endtask

    initial begin
        camera = '{pos_x: 0, pos_y: 0, dir_x: 16384, dir_y: 0, plane_x: 0,
                   plane_y: 10813, scr_w: 640, scr_h: 480};
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Default camera: extremes of the cells, the cell under the camera.
        send_cell(0, 0);
        send_cell(255, 255);
        send_cell(0, 255);
        send_cell(255, 0);
        send_cell(8'hAA, 8'h55);
        send_cell(8'h55, 8'hAA);
        drain_pipeline();

        // Parallel dir and plane give a zero determinant.
        write_register(CFG_PLANE_X, 24'd16384);
        write_register(CFG_PLANE_Y, 24'd0);
        send_cell(3, 3);
        drain_pipeline();

        // Sprite on the camera plane: depth zero. Height and width zero,
        // and an oversized width and height, exercise the clamps.
        write_register(CFG_PLANE_X, 24'd0);
        write_register(CFG_PLANE_Y, 24'd10813);
        write_register(CFG_POS_X, 24'h058000);
        write_register(CFG_POS_Y, 24'h008000);
        write_register(CFG_SCR_H, 24'd0);
        write_register(CFG_SCR_W, 24'd0);
        send_cell(5, 9);
        send_cell(6, 0);
        drain_pipeline();
        write_register(CFG_SCR_W, 24'h1FFF);
        write_register(CFG_SCR_H, 24'h1FFF);
        write_register(CFG_IDX_UNUSED, 24'h123456);
        send_cell(5, 0);
        send_cell(200, 0);
        drain_pipeline();

        random_camera(0);
        for (int i = 0; i < 8; i++) send_cell($urandom_range(0, 255), $urandom_range(0, 255));
        drain_pipeline();

        for (int phase = 0; phase < 8; phase++) begin
            random_camera(1);
            for (int i = 0; i < 80; i++) begin
                // Keep most sprites near the camera so size and bounds vary.
                if ($urandom_range(0, 3) != 0)
                    send_cell(camera.pos_x[23:16] + $urandom_range(0, 6) - 3,
                              camera.pos_y[23:16] + $urandom_range(0, 6) - 3);
                else
                    send_cell($urandom_range(0, 255), $urandom_range(0, 255));
            end
            i_start <= 1'b0;
            drain_pipeline();
        end

        i_start <= 1'b0;
        drain_pipeline();
        if (board.mismatch_count == 0 && board.unexpected_count == 0 &&
            board.pending_results.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end
endmodule
